[design/bpra_pkg.sv]
// Shared types, codes and helper functions of the bitmap page range allocator.
package bpra_pkg;

   typedef struct packed {
      logic        command;
      logic [14:0] page_number;
      logic [15:0] count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] start_page;
   } rsp_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_IGNORED  = 2'd2;

   localparam logic [5:0] WORD_BITS = 6'd32;

   // One bitmap word with the bit where the segment search starts.
   typedef struct packed {
      logic [31:0] used_word;
      logic [4:0]  bit_pos;
   } scan_req_type;

   // First free bit at or above bit_pos, then the first used bit above that one
   // (WORD_BITS when the free segment reaches the top of the word).
   typedef struct packed {
      logic       any_free;
      logic [4:0] first_free;
      logic [5:0] first_used;
   } scan_rsp_type;

   // Mask with the bits below n set; n of 32 or more gives all ones.
   function automatic logic [31:0] low_ones(input logic [5:0] n);
      logic [31:0] mask;
      if (n[5]) begin
         mask = '1;
      end else begin
         mask = (32'd1 << n[4:0]) - 32'd1;
      end
      return mask;
   endfunction

endpackage

[design/bitmap_page_range_allocator_unit.sv]
// First-fit page range allocator over a one-bit-per-page bitmap memory.
//
// A command word is taken on req_data when start is high and busy is low.
// Allocate asks for count contiguous pages at or above FIRST_USER_PAGE and
// returns the start page; free clears count pages from page_number on.
// Each command gives exactly one result word on rsp_data, marked by rsp_valid
// for one cycle; the receiver cannot stall, so it must take it then.
// Commands that are rejected or clear nothing answer in the cycle after
// they are taken. Allocate scans word by word: it reads a bitmap word, then
// examines it, and stays on that word for every further free segment inside
// it; a search that finds nothing answers once the scan has passed the last
// bitmap word. Marking the run then reads and writes each bitmap word it
// touches, and so does free. The single memory port pair sets this pace.
// A new command can be taken in the cycle that carries the previous result
// word, so commands that are rejected or clear nothing run back to back.
// After reset the block writes every word of the initial bitmap (reserved
// pages used) and holds busy high meanwhile.
module bitmap_page_range_allocator_unit #(
   parameter int PAGE_TOTAL      = 32768,
   parameter int FIRST_USER_PAGE = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bpra_pkg::req_type req_data,
   output logic              rsp_valid,
   output bpra_pkg::rsp_type rsp_data
);

   localparam int WORD_COUNT = (PAGE_TOTAL + 31) / 32;
   localparam int WA         = $clog2(WORD_COUNT);
   localparam int WCW        = $clog2(WORD_COUNT + 1);
   localparam int VW         = $clog2(PAGE_TOTAL + FIRST_USER_PAGE + 65537);

   localparam logic [VW-1:0]  PT_V       = VW'(PAGE_TOTAL);
   localparam logic [VW-1:0]  FUP_V      = VW'(FIRST_USER_PAGE);
   localparam logic [WCW-1:0] WORD_LAST  = WCW'(WORD_COUNT - 1);
   localparam logic [WCW-1:0] WORD_END   = WCW'(WORD_COUNT);
   localparam logic [WCW-1:0] FUP_WORD   = WCW'(FIRST_USER_PAGE / 32);
   localparam logic [4:0]     FUP_BIT    = 5'(FIRST_USER_PAGE % 32);
   localparam logic           USER_EMPTY = (FIRST_USER_PAGE >= PAGE_TOTAL);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_STEP,
      S_UPD_RD,
      S_UPD_WR
   } state_type;

   state_type         state_ff;
   logic [WCW-1:0]    word_ff;
   logic [4:0]        bit_ff;
   logic [VW-1:0]     run_len_ff;
   logic [VW-1:0]     run_start_ff;
   logic [15:0]       count_ff;
   logic [VW-1:0]     cur_ff;
   logic [VW-1:0]     end_ff;
   logic              set_ff;
   logic [14:0]       start_page_ff;
   logic              rsp_valid_ff;
   bpra_pkg::rsp_type rsp_data_ff;

   logic [VW-1:0] base;
   logic [5:0]    lo_n;
   logic [5:0]    hi_n;
   logic [31:0]   forced;
   logic [5:0]    seg_len;
   logic [VW-1:0] cont;
   logic [VW-1:0] run_total;
   logic [VW-1:0] cand_start;
   logic          fits;
   logic [VW-1:0] req_page;
   logic [VW-1:0] req_end;
   logic [VW-1:0] word_base_u;
   logic [VW-1:0] word_next;
   logic [5:0]    hi_u;
   logic [31:0]   upd_mask;
   logic [31:0]   upd_word;

   logic          wr_en;
   logic [WA-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          rd_en;
   logic [WA-1:0] rd_addr;
   logic [31:0]   rd_data;

   bpra_pkg::scan_req_type scan_req;
   bpra_pkg::scan_rsp_type scan_rsp;

   bpra_bitmap_ram #(
      .DEPTH  (WORD_COUNT),
      .ADDR_W (WA)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bpra_scan_step u_scan_step (
      .step_in  (scan_req),
      .step_out (scan_rsp)
   );

   // Pages below the user region or at and above the page total count as
   // used, so a found segment never leaves the legal range.
   always_comb begin
      base = VW'({word_ff, 5'b0});
      if (FUP_V <= base) begin
         lo_n = '0;
      end else if (FUP_V >= base + VW'(32)) begin
         lo_n = bpra_pkg::WORD_BITS;
      end else begin
         lo_n = {1'b0, FUP_V[4:0]};
      end
      if (PT_V >= base + VW'(32)) begin
         hi_n = bpra_pkg::WORD_BITS;
      end else begin
         hi_n = 6'(PT_V - base);
      end
      forced = bpra_pkg::low_ones(lo_n) | ~bpra_pkg::low_ones(hi_n);

      scan_req.used_word = rd_data | forced;
      scan_req.bit_pos   = bit_ff;

      seg_len    = 6'(scan_rsp.first_used - {1'b0, scan_rsp.first_free});
      cont       = (scan_rsp.first_free == bit_ff) ? run_len_ff : '0;
      run_total  = cont + VW'(seg_len);
      cand_start = (scan_rsp.first_free == bit_ff && run_len_ff != '0)
                   ? run_start_ff : base + VW'(scan_rsp.first_free);
      fits       = scan_rsp.any_free && (run_total >= VW'(count_ff));

      req_page = VW'(req_data.page_number);
      req_end  = req_page + VW'(req_data.count);

      word_base_u = {cur_ff[VW-1:5], 5'b0};
      word_next   = word_base_u + VW'(32);
      if (end_ff >= word_next) begin
         hi_u = bpra_pkg::WORD_BITS;
      end else begin
         hi_u = 6'(end_ff - word_base_u);
      end
      upd_mask = bpra_pkg::low_ones(hi_u) & ~bpra_pkg::low_ones({1'b0, cur_ff[4:0]});
      upd_word = set_ff ? (rd_data | upd_mask) : (rd_data & ~upd_mask);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = word_ff[WA-1:0];
      wr_data = bpra_pkg::low_ones(lo_n);
      rd_en   = 1'b0;
      rd_addr = word_ff[WA-1:0];
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_SCAN_RD: begin
            rd_en = (word_ff != WORD_END);
         end
         S_UPD_RD: begin
            rd_en   = 1'b1;
            rd_addr = cur_ff[WA+4:5];
         end
         S_UPD_WR: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff[WA+4:5];
            wr_data = upd_word;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               word_ff <= word_ff + WCW'(1);
               if (word_ff == WORD_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  count_ff      <= req_data.count;
                  run_len_ff    <= '0;
                  run_start_ff  <= '0;
                  word_ff       <= FUP_WORD;
                  bit_ff        <= FUP_BIT;
                  start_page_ff <= '0;
                  if (req_data.command == bpra_pkg::CMD_ALLOC) begin
                     if (req_data.count == '0 || USER_EMPTY) begin
                        rsp_valid_ff           <= 1'b1;
                        rsp_data_ff.status     <= bpra_pkg::STATUS_NO_SPACE;
                        rsp_data_ff.start_page <= '0;
                     end else begin
                        set_ff   <= 1'b1;
                        state_ff <= S_SCAN_RD;
                     end
                  end else if (req_page < FUP_V) begin
                     rsp_valid_ff           <= 1'b1;
                     rsp_data_ff.status     <= bpra_pkg::STATUS_IGNORED;
                     rsp_data_ff.start_page <= '0;
                  end else if (req_page >= PT_V || req_data.count == '0) begin
                     rsp_valid_ff           <= 1'b1;
                     rsp_data_ff.status     <= bpra_pkg::STATUS_DONE;
                     rsp_data_ff.start_page <= '0;
                  end else begin
                     set_ff   <= 1'b0;
                     cur_ff   <= req_page;
                     end_ff   <= (req_end > PT_V) ? PT_V : req_end;
                     state_ff <= S_UPD_RD;
                  end
               end
            end
            S_SCAN_RD: begin
               if (word_ff == WORD_END) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.status     <= bpra_pkg::STATUS_NO_SPACE;
                  rsp_data_ff.start_page <= '0;
                  state_ff               <= S_IDLE;
               end else begin
                  state_ff <= S_SCAN_STEP;
               end
            end
            S_SCAN_STEP: begin
               if (fits) begin
                  cur_ff        <= cand_start;
                  end_ff        <= cand_start + VW'(count_ff);
                  start_page_ff <= cand_start[14:0];
                  state_ff      <= S_UPD_RD;
               end else if (!scan_rsp.any_free || scan_rsp.first_used[5]
                            || scan_rsp.first_used == 6'd31) begin
                  // A segment that reaches the top of the word carries over.
                  word_ff      <= word_ff + WCW'(1);
                  bit_ff       <= '0;
                  run_len_ff   <= (scan_rsp.any_free && scan_rsp.first_used[5])
                                  ? run_total : '0;
                  run_start_ff <= cand_start;
                  state_ff     <= S_SCAN_RD;
               end else begin
                  run_len_ff <= '0;
                  bit_ff     <= scan_rsp.first_used[4:0] + 5'd1;
               end
            end
            S_UPD_RD: begin
               state_ff <= S_UPD_WR;
            end
            S_UPD_WR: begin
               cur_ff <= word_next;
               if (word_next >= end_ff) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.status     <= bpra_pkg::STATUS_DONE;
                  rsp_data_ff.start_page <= start_page_ff;
                  state_ff               <= S_IDLE;
               end else begin
                  state_ff <= S_UPD_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted word neither in progress nor answered");

   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != bpra_pkg::STATUS_DONE |-> rsp_data.start_page == '0)
      else $error("start page given without an allocation");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_STEP || state_ff == S_SCAN_RD |-> !wr_en)
      else $error("bitmap written during the search");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word issued while still working");
`endif

endmodule

[design/bpra_bitmap_ram.sv]
// Single-port-write, single-port-read bitmap memory with registered read data.
module bpra_bitmap_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bpra_scan_step.sv]
// Segment finder: locates the next free run of pages inside one bitmap word.
module bpra_scan_step (
   input  bpra_pkg::scan_req_type step_in,
   output bpra_pkg::scan_rsp_type step_out
);

   function automatic logic [5:0] lowest_set(input logic [31:0] v);
      logic [5:0] idx;
      idx = bpra_pkg::WORD_BITS;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) begin
            idx = 6'(i);
         end
      end
      return idx;
   endfunction

   logic [31:0] avail;
   logic [31:0] used_above;
   logic [5:0]  free_idx;

   always_comb begin
      avail      = ~step_in.used_word & ~bpra_pkg::low_ones({1'b0, step_in.bit_pos});
      free_idx   = lowest_set(avail);
      used_above = step_in.used_word & ~bpra_pkg::low_ones(free_idx);
      step_out.any_free   = |avail;
      step_out.first_free = free_idx[4:0];
      step_out.first_used = lowest_set(used_above);
   end

endmodule

[tb/tb_bitmap_page_range_allocator_unit.sv]
// Self-checking testbench for the first-fit bitmap page range allocator.
module tb_bitmap_page_range_allocator_unit;

   localparam int PAGE_TOTAL      = 32768;
   localparam int FIRST_USER_PAGE = 8192;
   localparam int ITEM_TARGET     = 580;
   localparam int IDLE_PCT        = 7;
   localparam int STALL_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 256;

   typedef struct packed {
      logic              typed;
      bpra_pkg::req_type word;
      bpra_pkg::rsp_type result;
   } stim_row_type;

   typedef struct {
      int first;
      int len;
   } page_run_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   bpra_pkg::req_type req_data = '0;
   logic              rsp_valid;
   bpra_pkg::rsp_type rsp_data;

   bit [0:PAGE_TOTAL-1] page_used;
   bpra_pkg::rsp_type   pending_results[$];
   page_run_type        alloc_runs[$];
   stim_row_type        directed_rows[$];

   logic              row_typed = 1'b0;
   bpra_pkg::rsp_type typed_result = '0;
   bit                idle_on = 1'b1;
   int                errors = 0;
   int                words_taken = 0;
   int                done_count = 0;
   int                no_space_count = 0;
   int                ignored_count = 0;
   int                stall_cycles = 0;

   bitmap_page_range_allocator_unit #(
      .PAGE_TOTAL      (PAGE_TOTAL),
      .FIRST_USER_PAGE (FIRST_USER_PAGE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Applies one command word to the shadow bitmap and returns the result word.
   function automatic bpra_pkg::rsp_type allocator_outcome(input bpra_pkg::req_type word);
      bpra_pkg::rsp_type result;
      int                run;
      int                first;
      int                last;
      int                p;
      bit                found;
      result.status     = bpra_pkg::STATUS_NO_SPACE;
      result.start_page = '0;
      if (word.command == bpra_pkg::CMD_ALLOC) begin
         run   = 0;
         found = 1'b0;
         // The first run to reach full length is also the one that starts lowest.
         for (p = FIRST_USER_PAGE; p < PAGE_TOTAL && !found && word.count != 0; p++) begin
            run = page_used[p] ? 0 : run + 1;
            if (run == int'(word.count)) begin
               found = 1'b1;
               first = p - run + 1;
               for (int q = first; q <= p; q++) page_used[q] = 1'b1;
               result.status     = bpra_pkg::STATUS_DONE;
               result.start_page = 15'(first);
            end
         end
      end else if (int'(word.page_number) < FIRST_USER_PAGE) begin
         result.status = bpra_pkg::STATUS_IGNORED;
      end else begin
         last = int'(word.page_number) + int'(word.count);
         if (last > PAGE_TOTAL) last = PAGE_TOTAL;
         for (p = int'(word.page_number); p < last; p++) page_used[p] = 1'b0;
         result.status = bpra_pkg::STATUS_DONE;
      end
      return result;
   endfunction

   function automatic stim_row_type stim_row(input logic cmd, input int page, input int count,
                                             input logic typed, input logic [1:0] status,
                                             input int first);
      stim_row_type r;
      r.typed                 = typed;
      r.word.command          = cmd;
      r.word.page_number      = 15'(page);
      r.word.count            = 16'(count);
      r.result.status         = status;
      r.result.start_page     = 15'(first);
      return r;
   endfunction

   // Half allocations, mostly of small sizes, and half frees, mostly of runs handed out earlier.
   function automatic bpra_pkg::req_type random_command();
      bpra_pkg::req_type w;
      page_run_type      r;
      int                pick;
      int                k;
      w.page_number = 15'($urandom);
      pick = $urandom_range(99);
      if (pick < 50) begin
         w.command = bpra_pkg::CMD_ALLOC;
         k = $urandom_range(99);
         if (k < 3) begin
            w.count = '0;
         end else if (k < 6) begin
            w.count = 16'($urandom_range(PAGE_TOTAL - FIRST_USER_PAGE + 1, 65535));
         end else if (k < 10) begin
            w.count = 16'($urandom_range(65, 512));
         end else begin
            w.count = 16'($urandom_range(1, 64));
         end
      end else begin
         w.command = bpra_pkg::CMD_FREE;
         k = $urandom_range(99);
         if (k < 70 && alloc_runs.size() > 0) begin
            pick = $urandom_range(alloc_runs.size() - 1);
            r = alloc_runs[pick];
            alloc_runs.delete(pick);
            w.page_number = 15'(r.first);
            if (r.len > 1 && $urandom_range(4) == 0) begin
               w.count = 16'(r.len / 2);
               alloc_runs.push_back('{first: r.first + r.len / 2, len: r.len - r.len / 2});
            end else begin
               w.count = 16'(r.len);
            end
         end else if (k < 82) begin
            w.page_number = 15'($urandom_range(0, FIRST_USER_PAGE - 1));
            w.count       = 16'($urandom);
         end else if (k < 98) begin
            w.page_number = 15'($urandom_range(FIRST_USER_PAGE, PAGE_TOTAL - 1));
            w.count       = 16'($urandom_range(0, 128));
         end else begin
            w.page_number = 15'($urandom_range(FIRST_USER_PAGE, PAGE_TOTAL - 1));
            w.count       = 16'($urandom);
         end
      end
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic issue(input bpra_pkg::req_type word, input logic typed,
                        input bpra_pkg::rsp_type result);
      bit taken;
      taken        = 1'b0;
      row_typed    = typed;
      typed_result = result;
      req_data <= word;
      while (!taken) begin
         if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
         end else begin
            start <= 1'b1;
         end
         @(posedge clock);
         taken = start && !busy;
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      bpra_pkg::rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = allocator_outcome(req_data);
            if (req_data.command == bpra_pkg::CMD_ALLOC && want.status == bpra_pkg::STATUS_DONE)
            begin
               alloc_runs.push_back('{first: int'(want.start_page), len: int'(req_data.count)});
            end
            if (row_typed) want = typed_result;
            pending_results.push_back(want);
            words_taken++;
         end
         if (rsp_valid) begin
            case (rsp_data.status)
               bpra_pkg::STATUS_DONE:     done_count++;
               bpra_pkg::STATUS_NO_SPACE: no_space_count++;
               default:                   ignored_count++;
            endcase
            if (pending_results.size() == 0) begin
               errors++;
               $error("result word with nothing expected: status %0d, start_page %0d",
                      rsp_data.status, rsp_data.start_page);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               end
               if (rsp_data.start_page !== want.start_page) begin
                  errors++;
                  $error("start_page: expected %0d, actual %0d",
                         want.start_page, rsp_data.start_page);
               end
            end
         end
      end
   end

   // The clearing pass after reset and the slowest scans stay far below this limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int                n;
      bpra_pkg::req_type w;
      page_used = '0;
      for (int p = 0; p < FIRST_USER_PAGE; p++) page_used[p] = 1'b1;
      directed_rows = {
         stim_row(bpra_pkg::CMD_ALLOC, 0,     1,     1'b1, bpra_pkg::STATUS_DONE,
                  FIRST_USER_PAGE),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     0,     1'b1, bpra_pkg::STATUS_NO_SPACE, 0),
         stim_row(bpra_pkg::CMD_ALLOC, 32767, 65535, 1'b1, bpra_pkg::STATUS_NO_SPACE, 0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     32768, 1'b1, bpra_pkg::STATUS_NO_SPACE, 0),
         stim_row(bpra_pkg::CMD_FREE,  0,     1,     1'b1, bpra_pkg::STATUS_IGNORED,  0),
         stim_row(bpra_pkg::CMD_FREE,  8191,  65535, 1'b1, bpra_pkg::STATUS_IGNORED,  0),
         stim_row(bpra_pkg::CMD_FREE,  8192,  1,     1'b1, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     24576, 1'b1, bpra_pkg::STATUS_DONE,
                  FIRST_USER_PAGE),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     1,     1'b1, bpra_pkg::STATUS_NO_SPACE, 0),
         stim_row(bpra_pkg::CMD_FREE,  32767, 65535, 1'b1, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     2,     1'b1, bpra_pkg::STATUS_NO_SPACE, 0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     1,     1'b1, bpra_pkg::STATUS_DONE,     32767),
         stim_row(bpra_pkg::CMD_FREE,  8192,  65535, 1'b1, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     24577, 1'b1, bpra_pkg::STATUS_NO_SPACE, 0),
         stim_row(bpra_pkg::CMD_FREE,  30000, 0,     1'b1, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_FREE,  20000, 100,   1'b1, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     2,     1'b0, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     31,    1'b0, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     33,    1'b0, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_FREE,  8193,  1,     1'b0, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     2,     1'b0, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_ALLOC, 0,     1,     1'b0, bpra_pkg::STATUS_DONE,     0),
         stim_row(bpra_pkg::CMD_FREE,  8192,  65535, 1'b0, bpra_pkg::STATUS_DONE,     0)
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
      end
      // The last directed word cleared the whole user region.
      alloc_runs.delete();

      n = 0;
      while (n < ITEM_TARGET) begin
         idle_on = !(n >= 200 && n < 330);
         w = random_command();
         issue(w, 1'b0, '0);
         n++;
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d command words: %0d done, %0d refused for lack of space,",
               words_taken, done_count, no_space_count);
      $display("and %0d frees turned away below the user region.", ignored_count);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
